// File: sv/ship_pkg.sv
`default_nettype none
package ship_pkg;

  localparam int SETS_DEF    = 2048;
  localparam int WAYS_DEF    = 16;
  localparam int ENTRIES_DEF = 4096;

  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int PC_W      = 11;
  localparam int KIND_W    = 2;
  localparam int VWAY_W    = 4;
  localparam int RRPV_W    = 2;
  localparam int CTR_W     = 2;
  localparam int SIG_RAW_W = 12;
  localparam int LEAD_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  localparam logic [RRPV_W-1:0] MAX_RRPV = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_MAX  = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_INIT = 2'd1;
  localparam int BYPASS_NEED = 14;

  localparam logic [KIND_W-1:0] KIND_LOAD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RFO       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PREFETCH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd3;

  localparam logic REQ_QUERY  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_TRAIN  = 1'b1;

  typedef struct packed {
    logic clr;
    logic latch;
    logic rd_old;
    logic cap_row;
    logic cap_old;
    logic exec;
  } ship_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ship_stat_t;

  // remainder by conditional subtraction, valid for v below 32*m
  function automatic logic [31:0] mod_red(input logic [31:0] v, input int unsigned m);
    logic [31:0] r;
    r = v;
    for (int k = 4; k >= 0; k--) begin
      if (r >= (m << k)) r = r - (m << k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/ship_req_if.sv
`default_nettype none
interface ship_req_if;
  import ship_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SET_IN_W-1:0] set_index;
  logic [WAY_IN_W-1:0] way_index;
  logic [PC_W-1:0]     pc_low;
  logic [KIND_W-1:0]   access_kind;
  logic                is_hit;
  logic                sample_draw;
  modport source (output valid, req_type, set_index, way_index, pc_low, access_kind,
                  is_hit, sample_draw, input ready);
  modport sink (input valid, req_type, set_index, way_index, pc_low, access_kind,
                is_hit, sample_draw, output ready);
endinterface
`default_nettype wire

// File: sv/ship_rsp_if.sv
`default_nettype none
interface ship_rsp_if;
  import ship_pkg::*;
  logic              valid;
  logic              ready;
  logic [VWAY_W-1:0] victim_way;
  logic              bypass;
  logic [RRPV_W-1:0] inserted_rrpv;
  modport source (output valid, victim_way, bypass, inserted_rrpv, input ready);
  modport sink (input valid, victim_way, bypass, inserted_rrpv, output ready);
endinterface
`default_nettype wire

// File: sv/ship_rrip_cache_replacement_top.sv
`default_nettype none
// channel   dir  handshake      payload
// req       in   valid/ready    req_type set_index way_index pc_low access_kind is_hit
//                               sample_draw
// rsp       out  valid/ready    victim_way bypass inserted_rrpv
// cfg       in   cfg_we         cfg_index cfg_data, no read-back
//
// result is valid after the accept and the states RDA, RDB, RDC and EXEC: set row and
// new-signature counter read, counter read at the line's stored signature, capture, then
// an execute step with all ways compared at once; the next item is accepted the cycle
// after execute
// reset runs a clearing pass over addresses 0 to max(SETS, TABLE_ENTRIES)-1 of the row
// and counter memories (0 to 4095 by default); no item is accepted meanwhile
// a result held in the output register does not block the next accept; only the
// execute cycle waits for that register to empty
module ship_rrip_cache_replacement_top import ship_pkg::*; #(
  parameter int SETS          = SETS_DEF,
  parameter int WAYS          = WAYS_DEF,
  parameter int TABLE_ENTRIES = ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  ship_req_if.sink                  req,
  ship_rsp_if.source                rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);
  ship_cmd_t  cmd;
  ship_stat_t stat;

  // sequencer: clearing pass, read steps, execute, result valid
  ship_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .stat(stat)
  );

  // set rows, signature counters, victim search and update rules
  ship_dp #(.SETS(SETS), .WAYS(WAYS), .TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_req_type(req.req_type), .in_set_index(req.set_index),
    .in_way_index(req.way_index), .in_pc_low(req.pc_low),
    .in_access_kind(req.access_kind), .in_is_hit(req.is_hit),
    .in_sample_draw(req.sample_draw),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .victim_way(rsp.victim_way), .bypass(rsp.bypass),
    .inserted_rrpv(rsp.inserted_rrpv)
  );

  a_bypass_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bypass |-> rsp.victim_way == '0 && rsp.inserted_rrpv == '0)
    else $error("bypass item carries a way");
endmodule
`default_nettype wire

// File: sv/ship_ram.sv
`default_nettype none
module ship_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/ship_ctrl.sv
`default_nettype none
module ship_ctrl import ship_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ship_cmd_t       cmd,
  input  wire ship_stat_t stat
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RDA, S_RDB, S_RDC, S_EXEC} state_t;
  state_t state;
  logic   fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    cmd         = '0;
    cmd.clr     = (state == S_CLEAR);
    cmd.latch   = in_valid && in_ready;
    cmd.rd_old  = (state == S_RDB);
    cmd.cap_row = (state == S_RDB);
    cmd.cap_old = (state == S_RDC);
    cmd.exec    = fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: if (stat.clr_last) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_RDA;
        S_RDA:   state <= S_RDB;
        S_RDB:   state <= S_RDC;
        S_RDC:   state <= S_EXEC;
        S_EXEC:  if (fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_RDA) else $error("accept did not start a read");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid) else $error("result load lost");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid && !in_ready) else $error("activity during clear");
endmodule
`default_nettype wire

// File: sv/ship_dp.sv
`default_nettype none
module ship_dp import ship_pkg::*; #(
  parameter int SETS          = SETS_DEF,
  parameter int WAYS          = WAYS_DEF,
  parameter int TABLE_ENTRIES = ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ship_cmd_t            cmd,
  output ship_stat_t                stat,
  input  wire logic                 in_req_type,
  input  wire logic [SET_IN_W-1:0]  in_set_index,
  input  wire logic [WAY_IN_W-1:0]  in_way_index,
  input  wire logic [PC_W-1:0]      in_pc_low,
  input  wire logic [KIND_W-1:0]    in_access_kind,
  input  wire logic                 in_is_hit,
  input  wire logic                 in_sample_draw,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output logic [VWAY_W-1:0]         victim_way,
  output logic                      bypass,
  output logic [RRPV_W-1:0]         inserted_rrpv
);
  localparam int SW    = $clog2(SETS);
  localparam int WW    = $clog2(WAYS);
  localparam int TW    = $clog2(TABLE_ENTRIES);
  localparam int GW    = (TW < SIG_RAW_W) ? TW : SIG_RAW_W;
  localparam int LB    = 4 + GW;
  localparam int RW    = WAYS * LB;
  localparam int CLR_N = (SETS > TABLE_ENTRIES) ? SETS : TABLE_ENTRIES;
  localparam int CW    = $clog2(CLR_N);
  localparam int YW    = $clog2(WAYS + 1);

  // line layout: {signature, reused, prefetched, rrpv}
  logic [LEAD_W-1:0] leader_offset;
  logic              always_train;

  logic              req_r, hit_r, draw_r;
  logic [KIND_W-1:0] kind_r;
  logic [SW-1:0]     set_r;
  logic [WW-1:0]     way_r;
  logic [TW-1:0]     sig_r;
  logic [RW-1:0]     row_r;
  logic [CTR_W-1:0]  ctr_sig_r, ctr_old_r;
  logic [CW-1:0]     clr_cnt;

  logic [RW-1:0]    row_q;
  logic [CTR_W-1:0] ctr_q;
  logic [TW-1:0]    old_q, ctr_raddr;

  logic             row_we, ctr_we;
  logic [SW-1:0]    row_waddr;
  logic [RW-1:0]    row_wdata, row_new;
  logic [TW-1:0]    ctr_waddr;
  logic [CTR_W-1:0] ctr_wdata, ctr_new;
  logic             row_upd, ctr_upd;
  logic [VWAY_W-1:0] vway_n;
  logic              byp_n;
  logic [RRPV_W-1:0] rrpv_n;

  logic          sampled;
  logic [WAYS-1:0] young_v;
  logic [YW-1:0] young;
  logic [RRPV_W-1:0] maxage, d, age_w;
  logic [WW-1:0] vic;
  logic [LB-1:0] line, line_n;
  logic [TW-1:0] old_sig;
  logic [CTR_W-1:0] c;

  assign stat.clr_last = (clr_cnt == CW'(CLR_N - 1));
  assign sampled = (set_r[LEAD_W-1:0] == leader_offset);
  assign old_q   = TW'(row_q[32'(way_r) * LB + 4 +: GW]);
  assign ctr_raddr = cmd.rd_old ? old_q : sig_r;

  always_comb begin
    row_new = row_r;
    row_upd = 1'b0;
    ctr_upd = 1'b0;
    ctr_new = ctr_old_r;
    vway_n  = '0;
    byp_n   = 1'b0;
    rrpv_n  = '0;
    maxage  = '0;
    vic     = '0;
    c       = ctr_sig_r;
    line    = row_r[32'(way_r) * LB +: LB];
    line_n  = line;
    old_sig = TW'(line[LB-1:4]);
    for (int w = 0; w < WAYS; w++) begin
      young_v[w] = row_r[w*LB +: RRPV_W] < (MAX_RRPV - 2'd1);
      if (row_r[w*LB +: RRPV_W] > maxage) maxage = row_r[w*LB +: RRPV_W];
    end
    young = YW'($countones(young_v));
    d = MAX_RRPV - maxage;
    for (int w = WAYS - 1; w >= 0; w--) begin
      age_w = row_r[w*LB +: RRPV_W] + d;
      row_new[w*LB +: RRPV_W] = age_w;
      if (age_w == MAX_RRPV) vic = WW'(w);
    end
    if (req_r == REQ_QUERY) begin
      if (!sampled && (kind_r == KIND_LOAD || kind_r == KIND_RFO) &&
          ctr_sig_r == '0 && 32'(young) >= BYPASS_NEED) begin
        byp_n   = 1'b1;
        row_new = row_r;
      end else begin
        row_upd = 1'b1;
        vway_n  = VWAY_W'(vic);
        rrpv_n  = MAX_RRPV;
      end
    end else begin
      row_new = row_r;
      if (hit_r) begin
        if (kind_r != KIND_WRITEBACK) begin
          if (kind_r == KIND_PREFETCH && line[2]) begin
            if (sampled && (draw_r || always_train)) begin
              ctr_upd   = 1'b1;
              ctr_new   = (ctr_old_r < CTR_MAX) ? ctr_old_r + 2'd1 : ctr_old_r;
              line_n[3] = 1'b1;
            end
          end else begin
            line_n[1:0] = line[2] ? MAX_RRPV : 2'd0;
            line_n[2]   = 1'b0;
            if (sampled && !line[3]) begin
              ctr_upd   = 1'b1;
              ctr_new   = (ctr_old_r < CTR_MAX) ? ctr_old_r + 2'd1 : ctr_old_r;
              line_n[3] = 1'b1;
            end
          end
        end
      end else begin
        if (sampled) begin
          ctr_upd = 1'b1;
          if (line[3]) ctr_new = (ctr_old_r < CTR_MAX) ? ctr_old_r + 2'd1 : ctr_old_r;
          else ctr_new = (ctr_old_r > 2'd0) ? ctr_old_r - 2'd1 : ctr_old_r;
          line_n[3] = 1'b0;
          line_n[LB-1:4] = GW'(sig_r);
          // trained entry is the new signature itself
          if (old_sig == sig_r) c = ctr_new;
        end
        line_n[2] = (kind_r == KIND_PREFETCH);
        priority if (kind_r == KIND_WRITEBACK) line_n[1:0] = MAX_RRPV;
        else if (c == '0) line_n[1:0] = MAX_RRPV;
        else if (c == CTR_MAX) line_n[1:0] = (kind_r == KIND_PREFETCH) ? 2'd1 : 2'd0;
        else line_n[1:0] = MAX_RRPV - 2'd1;
      end
      row_upd = 1'b1;
      row_new[32'(way_r) * LB +: LB] = line_n;
      rrpv_n = line_n[1:0];
    end
  end

  always_comb begin
    if (cmd.clr) begin
      row_we    = 32'(clr_cnt) < SETS;
      row_waddr = clr_cnt[SW-1:0];
      row_wdata = {WAYS{LB'(MAX_RRPV)}};
      ctr_we    = 32'(clr_cnt) < TABLE_ENTRIES;
      ctr_waddr = clr_cnt[TW-1:0];
      ctr_wdata = CTR_INIT;
    end else begin
      row_we    = cmd.exec && row_upd;
      row_waddr = set_r;
      row_wdata = row_new;
      ctr_we    = cmd.exec && ctr_upd;
      ctr_waddr = old_sig;
      ctr_wdata = ctr_new;
    end
  end

  ship_ram #(.W(RW), .D(SETS)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(set_r), .rdata(row_q)
  );

  ship_ram #(.W(CTR_W), .D(TABLE_ENTRIES)) u_ctrs (
    .clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
    .raddr(ctr_raddr), .rdata(ctr_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      leader_offset <= '0;
      always_train  <= 1'b0;
    end else begin
      if (cmd.clr && !stat.clr_last) clr_cnt <= clr_cnt + CW'(1);
      if (cfg_we && cfg_index == CFG_LEADER_OFFSET) leader_offset <= cfg_data[LEAD_W-1:0];
      if (cfg_we && cfg_index == CFG_ALWAYS_TRAIN) always_train <= cfg_data[0];
    end
    if (cmd.latch) begin
      req_r  <= in_req_type;
      hit_r  <= in_is_hit;
      draw_r <= in_sample_draw;
      kind_r <= in_access_kind;
      set_r  <= SW'(mod_red(32'(in_set_index), SETS));
      way_r  <= WW'(mod_red(32'(in_way_index), WAYS));
      sig_r  <= TW'(mod_red(32'({in_pc_low, in_access_kind == KIND_PREFETCH}),
                            TABLE_ENTRIES));
    end
    if (cmd.cap_row) begin
      row_r     <= row_q;
      ctr_sig_r <= ctr_q;
    end
    if (cmd.cap_old) ctr_old_r <= ctr_q;
    if (cmd.exec) begin
      victim_way    <= vway_n;
      bypass        <= byp_n;
      inserted_rrpv <= rrpv_n;
    end
  end
endmodule
`default_nettype wire

// File: tb/ship_tb_ifs.sv
`default_nettype none
// local copies are not needed: the block's interfaces live with the rtl
// this file only bundles the result type and scoreboard class used by the bench
package ship_tb_pkg;
  import ship_pkg::*;

  typedef struct packed {
    logic [VWAY_W-1:0] victim_way;
    logic              bypass;
    logic [RRPV_W-1:0] inserted_rrpv;
  } repl_result_t;

  class repl_scoreboard;
    repl_result_t pending[$];
    int mismatches;
    int unexpected;

    function new();
      mismatches = 0;
      unexpected = 0;
    endfunction

    function void note_item(repl_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(repl_result_t got);
      repl_result_t want;
      if (pending.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("result with nothing pending: way %0d bypass %0d rrpv %0d",
                   got.victim_way, got.bypass, got.inserted_rrpv);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display("mismatch: want way %0d bypass %0d rrpv %0d, got way %0d bypass %0d rrpv %0d",
                   want.victim_way, want.bypass, want.inserted_rrpv,
                   got.victim_way, got.bypass, got.inserted_rrpv);
      end
    endfunction
  endclass
endpackage
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
  import ship_pkg::*;
  import ship_tb_pkg::*;

  localparam int NSETS = SETS_DEF;
  localparam int NWAYS = WAYS_DEF;
  localparam int NENT  = ENTRIES_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  ship_req_if req ();
  ship_rsp_if rsp ();

  ship_rrip_cache_replacement_top i_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the block's memories
  logic [RRPV_W-1:0]    age_q [NSETS*NWAYS];
  logic                 pref_q [NSETS*NWAYS];
  logic                 reuse_q [NSETS*NWAYS];
  logic [SIG_RAW_W-1:0] sig_q [NSETS*NWAYS];
  logic [CTR_W-1:0]     ctr_q [NENT];
  logic [LEAD_W-1:0]    lead_off;
  logic                 train_all;

  repl_scoreboard sb;
  bit failed = 0;

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      age_q[i] = MAX_RRPV;
      pref_q[i] = 1'b0;
      reuse_q[i] = 1'b0;
      sig_q[i] = '0;
    end
    for (int i = 0; i < NENT; i++) ctr_q[i] = CTR_INIT;
    lead_off = '0;
    train_all = 1'b0;
  end

  function automatic void ctr_up(int s);
    if (ctr_q[s] != CTR_MAX) ctr_q[s] = ctr_q[s] + 1;
  endfunction

  function automatic void ctr_down(int s);
    if (ctr_q[s] != 0) ctr_q[s] = ctr_q[s] - 1;
  endfunction

  // computes the result of one accepted item and advances the predictor
  function automatic repl_result_t predict_replacement(
      logic rtype, logic [SET_IN_W-1:0] set_i, logic [WAY_IN_W-1:0] way_i,
      logic [PC_W-1:0] pc, logic [KIND_W-1:0] kind, logic hit, logic draw);
    repl_result_t r;
    int set_n, base, li, young, oldest, vic, sig, old_sig, d;
    bit sampled;
    r = '0;
    set_n = set_i % NSETS;
    base = set_n * NWAYS;
    sampled = ((set_n % 32) == lead_off);
    sig = ((int'(pc) << 1) | (kind == KIND_PREFETCH)) % NENT;
    if (rtype == REQ_QUERY) begin
      young = 0;
      oldest = 0;
      vic = 0;
      for (int i = 0; i < NWAYS; i++) begin
        if (age_q[base+i] < MAX_RRPV - 1) young++;
        if (age_q[base+i] > oldest) oldest = age_q[base+i];
      end
      // bypass: unsampled demand access with a dead signature into a hot set
      if (!sampled && (kind == KIND_LOAD || kind == KIND_RFO) && ctr_q[sig] == 0 &&
          young >= BYPASS_NEED) begin
        r.bypass = 1'b1;
        return r;
      end
      if (oldest < MAX_RRPV) begin
        d = MAX_RRPV - oldest;
        for (int i = 0; i < NWAYS; i++) age_q[base+i] = age_q[base+i] + d;
      end
      for (int i = NWAYS - 1; i >= 0; i--)
        if (age_q[base+i] == MAX_RRPV) vic = i;
      r.victim_way = vic[VWAY_W-1:0];
      r.inserted_rrpv = age_q[base+vic];
      return r;
    end
    li = base + (way_i % NWAYS);
    old_sig = sig_q[li] % NENT;
    if (hit) begin
      // writeback hits leave everything alone
      if (kind != KIND_WRITEBACK) begin
        if (kind == KIND_PREFETCH && pref_q[li]) begin
          if (sampled && (draw || train_all)) begin
            ctr_up(old_sig);
            reuse_q[li] = 1'b1;
          end
        end else begin
          age_q[li] = pref_q[li] ? MAX_RRPV : '0;
          pref_q[li] = 1'b0;
          if (sampled && !reuse_q[li]) begin
            ctr_up(old_sig);
            reuse_q[li] = 1'b1;
          end
        end
      end
    end else begin
      // unsampled fills keep the stale signature
      if (sampled) begin
        if (reuse_q[li]) ctr_up(old_sig);
        else ctr_down(old_sig);
        reuse_q[li] = 1'b0;
        sig_q[li] = sig;
      end
      pref_q[li] = (kind == KIND_PREFETCH);
      if (kind == KIND_WRITEBACK || ctr_q[sig] == 0) age_q[li] = MAX_RRPV;
      else if (ctr_q[sig] == CTR_MAX) age_q[li] = (kind == KIND_PREFETCH) ? 2'd1 : 2'd0;
      else age_q[li] = MAX_RRPV - 1;
    end
    r.inserted_rrpv = age_q[li];
    return r;
  endfunction

  // sender side: idle driving values
  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_QUERY;
    req.set_index = '0;
    req.way_index = '0;
    req.pc_low = '0;
    req.access_kind = KIND_LOAD;
    req.is_hit = 1'b0;
    req.sample_draw = 1'b0;
    rsp.ready = 1'b0;
  end

  // accepted items go to the predictor, results to the checker
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      sb.note_item(predict_replacement(req.req_type, req.set_index, req.way_index,
                                       req.pc_low, req.access_kind, req.is_hit,
                                       req.sample_draw));
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result({rsp.victim_way, rsp.bypass, rsp.inserted_rrpv});
  end

  // receiver stalls: runs of ready and stall of random length, sometimes long-on
  initial begin
    int run;
    @(negedge rst);
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk) rsp.ready <= 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        run = $urandom_range(1, 6);
        repeat (run) @(posedge clk) rsp.ready <= 1'b0;
      end
    end
  end

  int burst_left = 0;

  // sends one item, sometimes inserting a gap between bursts
  task automatic send_item(logic rtype, logic [SET_IN_W-1:0] set_i,
                           logic [WAY_IN_W-1:0] way_i, logic [PC_W-1:0] pc,
                           logic [KIND_W-1:0] kind, logic hit, logic draw);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.req_type <= rtype;
    req.set_index <= set_i;
    req.way_index <= way_i;
    req.pc_low <= pc;
    req.access_kind <= kind;
    req.is_hit <= hit;
    req.sample_draw <= draw;
    do @(posedge clk); while (!req.ready);
  endtask

  // lowers valid and waits until every pending result is back, plus drain time
  task automatic drain_block();
    req.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // drives one write, then holds cfg_we low before returning so back-to-back writes stay apart
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LEADER_OFFSET) lead_off = val[LEAD_W-1:0];
    else train_all = val[0];
    @(posedge clk);
  endtask

  // fills every way of a set with one kind
  task automatic warm_set(logic [SET_IN_W-1:0] set_i, logic [PC_W-1:0] pc,
                          logic [KIND_W-1:0] kind);
    for (int w = 0; w < NWAYS; w++)
      send_item(REQ_UPDATE, set_i, w, pc, kind, 1'b0, 1'b0);
  endtask

  // random item mix: mostly sequences on a few hot sets so ages and counters move
  task automatic random_item(logic [SET_IN_W-1:0] hot);
    logic [SET_IN_W-1:0] s;
    logic [PC_W-1:0] pc;
    int pick;
    pick = $urandom_range(0, 9);
    s = (pick < 7) ? (hot + $urandom_range(0, 3) * 32) : $urandom;
    pc = (pick < 8) ? $urandom_range(0, 7) : $urandom;
    if ($urandom_range(0, 3) == 0)
      send_item(REQ_QUERY, s, $urandom, pc, $urandom, $urandom, $urandom);
    else
      send_item(REQ_UPDATE, s, $urandom, pc, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [SET_IN_W-1:0] hot;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and every access kind on a sampled set (offset 0)
    send_item(REQ_QUERY, 11'd0, 4'd0, 11'd0, KIND_LOAD, 1'b0, 1'b0);
    send_item(REQ_UPDATE, 11'd0, 4'd15, 11'h7FF, KIND_PREFETCH, 1'b0, 1'b1);
    send_item(REQ_UPDATE, 11'd0, 4'd15, 11'h7FF, KIND_PREFETCH, 1'b1, 1'b1);
    send_item(REQ_UPDATE, 11'd0, 4'd15, 11'h7FF, KIND_LOAD, 1'b1, 1'b0);
    send_item(REQ_UPDATE, 11'd0, 4'd3, 11'd5, KIND_WRITEBACK, 1'b1, 1'b0);
    send_item(REQ_UPDATE, 11'd0, 4'd3, 11'd5, KIND_WRITEBACK, 1'b0, 1'b0);
    send_item(REQ_UPDATE, 11'd0, 4'd3, 11'd5, KIND_RFO, 1'b0, 1'b0);
    send_item(REQ_UPDATE, 11'd0, 4'd3, 11'd5, KIND_RFO, 1'b1, 1'b0);
    send_item(REQ_QUERY, 11'h7FF, 4'd15, 11'h7FF, KIND_WRITEBACK, 1'b1, 1'b1);
    // stale signature: unsampled fill then query
    send_item(REQ_UPDATE, 11'd33, 4'd1, 11'd9, KIND_LOAD, 1'b0, 1'b0);
    send_item(REQ_QUERY, 11'd33, 4'd0, 11'd9, KIND_PREFETCH, 1'b0, 1'b0);
    drain_block();

    // drive counter of pc 0 load to zero via sampled refills without reuse
    write_reg(CFG_ALWAYS_TRAIN, 5'd1);
    for (int k = 0; k < 3; k++) warm_set(11'd0, 11'd0, KIND_LOAD);
    drain_block();
    // fill an unsampled set young with a hot pc, then query with the dead one
    write_reg(CFG_LEADER_OFFSET, 5'd31);
    for (int k = 0; k < 4; k++) warm_set(11'd64, 11'd1, KIND_LOAD);
    for (int k = 0; k < 4; k++) warm_set(11'd31, 11'd1, KIND_LOAD);
    for (int w = 0; w < NWAYS; w++) send_item(REQ_UPDATE, 11'd64, w, 11'd1, KIND_LOAD, 1'b1, 1'b0);
    send_item(REQ_QUERY, 11'd64, 4'd0, 11'd0, KIND_LOAD, 1'b0, 1'b0);
    send_item(REQ_QUERY, 11'd64, 4'd0, 11'd0, KIND_RFO, 1'b0, 1'b0);
    drain_block();

    // random phases, each after writing the leader offset and always-train registers
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_LEADER_OFFSET, (ph == 0) ? 5'd0 : (ph == 1) ? 5'd31 : $urandom);
      write_reg(CFG_ALWAYS_TRAIN, ph[0]);
      hot = (ph < 2) ? ((ph == 0) ? 11'd0 : 11'd31) : lead_off + 32 * $urandom_range(0, 3);
      for (int n = 0; n < 300; n++) random_item(($urandom_range(0, 2) == 0) ? hot + 1 : hot);
      drain_block();
    end

    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0 && !failed)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: ship_rrip_cache_replacement_top.f
sv/ship_pkg.sv
sv/ship_req_if.sv
sv/ship_rsp_if.sv
sv/ship_ram.sv
sv/ship_ctrl.sv
sv/ship_dp.sv
sv/ship_rrip_cache_replacement_top.sv
tb/ship_tb_ifs.sv
tb/testbench.sv
